### src/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg
// shared types, constants and tables for the jtag scan sequencer
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned CountW  = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned SampleW = 4;

  localparam logic [CountW-1:0] MaxScanBits = 7'd64;

  localparam logic [1:0] ModeReset = 2'd0;
  localparam logic [1:0] ModeIr    = 2'd1;
  localparam logic [1:0] ModeDr    = 2'd2;

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhPre    = 5'b00010,
    PhShift  = 5'b00100,
    PhUpdate = 5'b01000,
    PhFinal  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic              start_req;
    logic [1:0]        mode;
    logic [CountW-1:0] bit_count;
    logic [DataW-1:0]  shift_in;
    logic              tdo;
  } in_req_t;

  typedef struct packed {
    logic             tck;
    logic             tms;
    logic             tdi;
    logic             busy_res;
    logic             done_res;
    logic [DataW-1:0] shift_out;
  } res_t;

  // tms pattern of the tap stepping clocks, bit n for clock n
  function automatic logic [7:0] pre_tms(input logic [1:0] kind);
    logic [7:0] pat;
    case (kind)
      ModeReset: pat = 8'h1f;
      ModeIr:    pat = 8'h03;
      ModeDr:    pat = 8'h01;
      default:   pat = 8'h1f;
    endcase
    return pat;
  endfunction

  // number of samples in the tap stepping part
  function automatic logic [SampleW-1:0] pre_end(input logic [1:0] kind);
    logic [SampleW-1:0] n;
    case (kind)
      ModeReset: n = 4'd12;
      ModeIr:    n = 4'd8;
      ModeDr:    n = 4'd6;
      default:   n = 4'd12;
    endcase
    return n;
  endfunction

endpackage

### src/jss_in_stage.sv
// ----------------------------------------------------------------------------
// jss_in_stage
// input register holding one tick request until the sequencer takes it
// ----------------------------------------------------------------------------
module jss_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  jss_pkg::in_req_t req_i,
  input  logic             advance_i,
  output logic             valid_o,
  output jss_pkg::in_req_t req_o
);

  logic             valid_q;
  logic             valid_d;
  jss_pkg::in_req_t req_q;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

### src/jss_seq.sv
// ----------------------------------------------------------------------------
// jss_seq
// sequencer state and per-tick pin, capture and done logic
// ----------------------------------------------------------------------------
module jss_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  jss_pkg::in_req_t req_i,
  output jss_pkg::res_t    res_o
);

  jss_pkg::phase_e                     phase_q, phase_d;
  logic [jss_pkg::SampleW-1:0]         sample_q, sample_d;
  logic [jss_pkg::CountW-1:0]          bit_q, bit_d;
  logic [1:0]                          kind_q, kind_d;
  logic [jss_pkg::CountW-1:0]          len_q, len_d;
  logic [jss_pkg::DataW-1:0]           send_q, send_d;
  logic [jss_pkg::DataW-1:0]           cap_q, cap_d;

  always_comb begin
    logic [jss_pkg::CountW-1:0]  cnt;
    logic [2:0]                  step;
    logic [jss_pkg::PosW-1:0]    pos;
    logic [jss_pkg::SampleW-1:0] si_n;
    logic [jss_pkg::CountW-1:0]  bi_n;
    logic [7:0]                  pat;

    phase_d  = phase_q;
    sample_d = sample_q;
    bit_d    = bit_q;
    kind_d   = kind_q;
    len_d    = len_q;
    send_d   = send_q;
    cap_d    = cap_q;
    cnt      = req_i.bit_count;

    res_o = '0;
    res_o.tms = 1'b1;
    res_o.tdi = 1'b1;

    // start from idle
    if (phase_q == jss_pkg::PhIdle && req_i.start_req && req_i.mode <= jss_pkg::ModeDr) begin
      if (cnt == '0) begin
        cnt = 7'd1;
      end else if (cnt > jss_pkg::MaxScanBits) begin
        cnt = jss_pkg::MaxScanBits;
      end
      kind_d   = req_i.mode;
      len_d    = cnt;
      send_d   = req_i.shift_in;
      cap_d    = '0;
      sample_d = '0;
      bit_d    = '0;
      phase_d  = jss_pkg::PhPre;
    end

    pos  = bit_d[jss_pkg::PosW-1:0];
    step = sample_d[3:1];
    si_n = sample_d + 4'd1;
    bi_n = bit_d + 7'd1;
    pat  = jss_pkg::pre_tms(kind_d);

    case (phase_d)
      jss_pkg::PhPre: begin
        res_o.busy_res = 1'b1;
        res_o.tck      = sample_d[0];
        res_o.tms      = pat[step];
        sample_d       = si_n;
        if (si_n >= jss_pkg::pre_end(kind_d)) begin
          sample_d = '0;
          bit_d    = '0;
          phase_d  = (kind_d == jss_pkg::ModeReset) ? jss_pkg::PhFinal : jss_pkg::PhShift;
        end
      end
      jss_pkg::PhShift: begin
        res_o.busy_res = 1'b1;
        res_o.tck      = sample_d[0];
        res_o.tms      = (bi_n == len_d);
        res_o.tdi      = send_d[pos];
        if (sample_d[0]) begin
          cap_d[pos] = cap_d[pos] | req_i.tdo;
          bit_d      = bi_n;
          sample_d   = '0;
          if (bi_n >= len_d) begin
            phase_d = jss_pkg::PhUpdate;
          end
        end else begin
          sample_d = 4'd1;
        end
      end
      jss_pkg::PhUpdate: begin
        res_o.busy_res = 1'b1;
        res_o.tck      = sample_d[0];
        if (sample_d[0]) begin
          sample_d = '0;
          phase_d  = jss_pkg::PhFinal;
        end else begin
          sample_d = 4'd1;
        end
      end
      jss_pkg::PhFinal: begin
        res_o.busy_res  = 1'b1;
        res_o.done_res  = 1'b1;
        res_o.shift_out = cap_d;
        sample_d        = '0;
        phase_d         = jss_pkg::PhIdle;
      end
      default: begin
        phase_d = jss_pkg::PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= jss_pkg::PhIdle;
      sample_q <= '0;
      bit_q    <= '0;
      kind_q   <= '0;
      len_q    <= '0;
      send_q   <= '0;
      cap_q    <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      sample_q <= sample_d;
      bit_q    <= bit_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      send_q   <= send_d;
      cap_q    <= cap_d;
    end
  end

endmodule

### src/jss_out_stage.sv
// ----------------------------------------------------------------------------
// jss_out_stage
// result register holding one tick result until the sink takes it
// ----------------------------------------------------------------------------
module jss_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  jss_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output jss_pkg::res_t res_o
);

  logic          valid_q;
  logic          valid_d;
  jss_pkg::res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### src/jtag_scan_sequencer.sv
// ----------------------------------------------------------------------------
// jtag_scan_sequencer
// jtag master driving tck, tms and tdi one half-period per request
//
//   channel  | dir | tdata (low bit up)                               | tuser | tlast
//   s_axis   | in  | start_req, bit_count[6:0], shift_in[63:0], tdo   | mode  | -
//   m_axis   | out | tck, tms, tdi, busy_res, shift_out[63:0]         | -     | done_res
//
// one request in, one result out, one per clock while the sink keeps taking
// each request passes the input register, then the result register
// the phase, counters and shift words update only when a request moves on
// a stalled sink holds both registers, input keeps taking until they fill
// reset idles the sequencer with pins at tck 0, tms 1, tdi 1
// ----------------------------------------------------------------------------
module jtag_scan_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // start_req, bit_count, shift_in, tdo
  input  logic [1:0]  s_axis_tuser_i,  // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // tck, tms, tdi, busy_res, shift_out
  output logic        m_axis_tlast_o   // done_res
);

  jss_pkg::in_req_t in_req;
  jss_pkg::in_req_t st_req;
  jss_pkg::res_t    seq_res;
  jss_pkg::res_t    out_res;
  logic             st_valid;
  logic             out_free;
  logic             advance;

  assign in_req.start_req = s_axis_tdata_i[0];
  assign in_req.bit_count = s_axis_tdata_i[7:1];
  assign in_req.shift_in  = s_axis_tdata_i[71:8];
  assign in_req.tdo       = s_axis_tdata_i[72];
  assign in_req.mode      = s_axis_tuser_i;

  assign advance = st_valid && out_free;

  jss_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .req_i     (in_req),
    .advance_i (advance),
    .valid_o   (st_valid),
    .req_o     (st_req)
  );

  jss_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (st_req),
    .res_o     (seq_res)
  );

  jss_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (seq_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {4'b0000, out_res.shift_out, out_res.busy_res,
                           out_res.tdi, out_res.tms, out_res.tck};
  assign m_axis_tlast_o = out_res.done_res;

  // done sample is the idle pin pattern and part of the sequence
  a_done_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o[3] && !m_axis_tdata_o[0] && m_axis_tdata_o[1] && m_axis_tdata_o[2])
    else $error("done sample without idle pins or busy");

  // outside a sequence nothing is captured
  a_idle_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[3] |->
      !m_axis_tlast_o && m_axis_tdata_o[67:4] == 64'd0)
    else $error("captured word outside a sequence");

  // input only stalls when both registers are full and the sink holds
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> st_valid && m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a full pipeline");

  // a moving request always lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("advanced request lost");

endmodule
